FILE: src/complex_arithmetic_unit_macros.svh
// Assertion macros of the complex arithmetic unit, used by its top level.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cau assertion failed");

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cau assertion failed");

`endif

FILE: src/cau_pkg.sv
// Types, codes and helpers of the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIV_STAGES        = 32;

   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_CMP = 3'd4;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] x_re;
      logic signed [31:0] x_im;
      logic signed [31:0] y_re;
      logic signed [31:0] y_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               equal;
      logic               div_by_zero;
      logic               saturated;
   } rsp_type;

   // Results that bypass the divider travel in this sideband.
   typedef struct packed {
      logic               is_div;
      logic               dz;
      logic               neg_re;
      logic               neg_im;
      logic               ovf_re;
      logic               ovf_im;
      logic signed [31:0] pre_re;
      logic signed [31:0] pre_im;
      logic               pre_sat;
      logic               equal;
   } side_type;

   // Front end output: sideband plus divider start values.
   typedef struct packed {
      side_type    side;
      logic [63:0] d;
      logic [63:0] r_re;
      logic [63:0] r_im;
      logic [31:0] m_re;
      logic [31:0] m_im;
   } front_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } sat_type;

   // Clamp a 33-bit signed sum to 32 bits.
   function automatic sat_type sat33(input logic signed [32:0] s);
      sat_type o;
      if (s[32] != s[31]) begin
         o.val = s[32] ? SAT_MIN : SAT_MAX;
         o.sat = 1'b1;
      end else begin
         o.val = s[31:0];
         o.sat = 1'b0;
      end
      return o;
   endfunction

   // Apply sign to a magnitude quotient and clamp.
   function automatic sat_type sat_quo(input logic [31:0] q, input logic ovf,
                                       input logic neg);
      sat_type o;
      if (neg) begin
         if (ovf || (q > 32'h8000_0000)) begin
            o.val = SAT_MIN;
            o.sat = 1'b1;
         end else begin
            o.val = -q;
            o.sat = 1'b0;
         end
      end else if (ovf || q[31]) begin
         o.val = SAT_MAX;
         o.sat = 1'b1;
      end else begin
         o.val = q;
         o.sat = 1'b0;
      end
      return o;
   endfunction

endpackage

FILE: src/cau_front.sv
// Front end: products, sums, add/sub/multiply results and divider setup (4 stages).
module cau_front import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  req_type   in_data,
   output logic      out_valid,
   output front_type out_data
);

   localparam int MW = 64 + FRAC_BITS;

   // stage 1: products, add/sub
   logic               s1_valid_ff;
   logic               s1_mul_ff, s1_div_ff, s1_eq_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_yr_ff, p_yi_ff;
   sat_type            s1_re_ff, s1_im_ff;
   sat_type            s1_re_in, s1_im_in;
   logic signed [31:0] xr, xi, yr, yi;
   logic signed [32:0] sum_re, sum_im;

   assign xr = in_data.x_re;
   assign xi = in_data.x_im;
   assign yr = in_data.y_re;
   assign yi = in_data.y_im;

   always_comb begin
      sum_re   = '0;
      sum_im   = '0;
      s1_re_in = '0;
      s1_im_in = '0;
      case (in_data.func)
         FUNC_ADD: begin
            sum_re   = {xr[31], xr} + {yr[31], yr};
            sum_im   = {xi[31], xi} + {yi[31], yi};
            s1_re_in = sat33(sum_re);
            s1_im_in = sat33(sum_im);
         end
         FUNC_SUB: begin
            sum_re   = {xr[31], xr} - {yr[31], yr};
            sum_im   = {xi[31], xi} - {yi[31], yi};
            s1_re_in = sat33(sum_re);
            s1_im_in = sat33(sum_im);
         end
         default: begin
            s1_re_in = '0;
            s1_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_rr_ff   <= 64'(xr) * 64'(yr);
         p_ii_ff   <= 64'(xi) * 64'(yi);
         p_ri_ff   <= 64'(xr) * 64'(yi);
         p_ir_ff   <= 64'(xi) * 64'(yr);
         p_yr_ff   <= 64'(yr) * 64'(yr);
         p_yi_ff   <= 64'(yi) * 64'(yi);
         s1_mul_ff <= (in_data.func == FUNC_MUL);
         s1_div_ff <= (in_data.func == FUNC_DIV);
         s1_eq_ff  <= (xr == yr) && (xi == yi);
         s1_re_ff  <= s1_re_in;
         s1_im_ff  <= s1_im_in;
      end
   end

   // stage 2: wide sums
   logic               s2_valid_ff;
   logic               s2_mul_ff, s2_div_ff, s2_eq_ff;
   logic signed [64:0] w_re_ff, w_im_ff;
   logic [63:0]        s2_d_ff;
   sat_type            s2_re_ff, s2_im_ff;
   logic signed [64:0] e_rr, e_ii, e_ri, e_ir;

   assign e_rr = {p_rr_ff[63], p_rr_ff};
   assign e_ii = {p_ii_ff[63], p_ii_ff};
   assign e_ri = {p_ri_ff[63], p_ri_ff};
   assign e_ir = {p_ir_ff[63], p_ir_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_re_ff   <= s1_div_ff ? (e_rr + e_ii) : (e_rr - e_ii);
         w_im_ff   <= s1_div_ff ? (e_ir - e_ri) : (e_ri + e_ir);
         s2_d_ff   <= 64'(p_yr_ff) + 64'(p_yi_ff);
         s2_mul_ff <= s1_mul_ff;
         s2_div_ff <= s1_div_ff;
         s2_eq_ff  <= s1_eq_ff;
         s2_re_ff  <= s1_re_ff;
         s2_im_ff  <= s1_im_ff;
      end
   end

   // stage 3: multiply scaling and clamp, divide magnitudes
   logic               s3_valid_ff;
   logic               s3_div_ff, s3_eq_ff, s3_neg_re_ff, s3_neg_im_ff;
   logic [MW-1:0]      s3_m_re_ff, s3_m_im_ff;
   logic [63:0]        s3_d_ff;
   sat_type            s3_re_ff, s3_im_ff;
   sat_type            s3_re_in, s3_im_in;
   logic signed [64:0] sh_re, sh_im, a_re, a_im;

   always_comb begin
      sh_re = w_re_ff >>> FRAC_BITS;
      sh_im = w_im_ff >>> FRAC_BITS;
      a_re  = w_re_ff[64] ? -w_re_ff : w_re_ff;
      a_im  = w_im_ff[64] ? -w_im_ff : w_im_ff;
      s3_re_in = s2_re_ff;
      s3_im_in = s2_im_ff;
      if (s2_mul_ff) begin
         if (sh_re[64:31] == {34{sh_re[31]}}) begin
            s3_re_in.val = sh_re[31:0];
            s3_re_in.sat = 1'b0;
         end else begin
            s3_re_in.val = sh_re[64] ? SAT_MIN : SAT_MAX;
            s3_re_in.sat = 1'b1;
         end
         if (sh_im[64:31] == {34{sh_im[31]}}) begin
            s3_im_in.val = sh_im[31:0];
            s3_im_in.sat = 1'b0;
         end else begin
            s3_im_in.val = sh_im[64] ? SAT_MIN : SAT_MAX;
            s3_im_in.sat = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_m_re_ff   <= MW'(a_re[63:0]) << FRAC_BITS;
         s3_m_im_ff   <= MW'(a_im[63:0]) << FRAC_BITS;
         s3_neg_re_ff <= w_re_ff[64];
         s3_neg_im_ff <= w_im_ff[64];
         s3_d_ff      <= s2_d_ff;
         s3_div_ff    <= s2_div_ff;
         s3_eq_ff     <= s2_eq_ff;
         s3_re_ff     <= s3_re_in;
         s3_im_ff     <= s3_im_in;
      end
   end

   // stage 4: quotient overflow check and divider start
   logic        s4_valid_ff;
   front_type   s4_ff, s4_in;
   logic [63:0] hi_re, hi_im;

   always_comb begin
      hi_re = 64'(s3_m_re_ff[MW-1:32]);
      hi_im = 64'(s3_m_im_ff[MW-1:32]);
      s4_in.d           = s3_d_ff;
      s4_in.m_re        = s3_m_re_ff[31:0];
      s4_in.m_im        = s3_m_im_ff[31:0];
      s4_in.side.ovf_re = (hi_re >= s3_d_ff);
      s4_in.side.ovf_im = (hi_im >= s3_d_ff);
      s4_in.r_re        = s4_in.side.ovf_re ? '0 : hi_re;
      s4_in.r_im        = s4_in.side.ovf_im ? '0 : hi_im;
      s4_in.side.is_div = s3_div_ff;
      s4_in.side.dz     = s3_div_ff && (s3_d_ff == '0);
      s4_in.side.neg_re = s3_neg_re_ff;
      s4_in.side.neg_im = s3_neg_im_ff;
      s4_in.side.pre_re = s3_re_ff.val;
      s4_in.side.pre_im = s3_im_ff.val;
      s4_in.side.pre_sat = s3_re_ff.sat | s3_im_ff.sat;
      s4_in.side.equal  = s3_eq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

FILE: src/cau_div_lane.sv
// Restoring divider lane, one quotient bit per pipeline stage.
module cau_div_lane import cau_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] d_in,
   input  logic [63:0] r_in,
   input  logic [31:0] m_in,
   output logic [31:0] q_out
);

   logic [63:0] d_ff [DIV_STAGES];
   logic [63:0] r_ff [DIV_STAGES];
   logic [31:0] m_ff [DIV_STAGES];
   logic [31:0] q_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [63:0] d_prev, r_prev;
      logic [31:0] m_prev, q_prev;
      logic [64:0] r2;
      logic        ge;

      if (k == 0) begin : g_first
         assign d_prev = d_in;
         assign r_prev = r_in;
         assign m_prev = m_in;
         assign q_prev = '0;
      end else begin : g_next
         assign d_prev = d_ff[k-1];
         assign r_prev = r_ff[k-1];
         assign m_prev = m_ff[k-1];
         assign q_prev = q_ff[k-1];
      end

      assign r2 = {r_prev, m_prev[31]};
      assign ge = (r2 >= {1'b0, d_prev});

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_prev;
            r_ff[k] <= ge ? 64'(r2 - {1'b0, d_prev}) : r2[63:0];
            m_ff[k] <= {m_prev[30:0], 1'b0};
            q_ff[k] <= {q_prev[30:0], ge};
         end
      end
   end

   assign q_out = q_ff[DIV_STAGES-1];

endmodule

FILE: src/complex_arithmetic_unit.sv
// Top level of the pipelined complex arithmetic unit.
//
// req channel: one transfer carries func and operands x, y (signed fixed point,
//   FRAC_BITS fraction bits). func: add, subtract, multiply, divide, compare.
// rsp channel: one transfer per request, in order: res_re, res_im, equal,
//   div_by_zero, saturated. Compare and unused codes give zero parts.
// Throughput: one transfer per cycle in each direction while rsp is not stalled.
// Path: from req transfer to rsp valid, a request passes four front stages
//   (multipliers, wide sums, scaling/magnitude, quotient range check), one
//   stage per quotient bit in the 32-stage divider, one output register.
//   Every function takes the same path, so order is kept.
// Stall: the whole pipeline advances together. When rsp_valid is high and
//   rsp_stall is high, every stage holds and req_stall rises; bubbles ahead
//   of the output keep moving otherwise.
// Reset: clears all valid bits; no result is pending afterward. The block
//   needs no warm-up and accepts a request in the first cycle after reset.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      en;
   logic      front_valid;
   front_type front_data;
   logic [31:0] q_re, q_im;

   // pipeline advances unless a finished result is held back
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   cau_div_lane u_div_re (
      .clock (clock),
      .en    (en),
      .d_in  (front_data.d),
      .r_in  (front_data.r_re),
      .m_in  (front_data.m_re),
      .q_out (q_re)
   );

   cau_div_lane u_div_im (
      .clock (clock),
      .en    (en),
      .d_in  (front_data.d),
      .r_in  (front_data.r_im),
      .m_in  (front_data.m_im),
      .q_out (q_im)
   );

   // sideband and valid bits ride alongside the divider stages
   logic     v_ff    [DIV_STAGES];
   side_type side_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= (k == 0) ? front_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= (k == 0) ? front_data.side : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // final sign, clamp and result select
   side_type sd;
   sat_type  qr, qi;

   assign sd = side_ff[DIV_STAGES-1];
   assign qr = sat_quo(q_re, sd.ovf_re, sd.neg_re);
   assign qi = sat_quo(q_im, sd.ovf_im, sd.neg_im);

   always_comb begin
      rsp_in.equal = sd.equal;
      if (!sd.is_div) begin
         rsp_in.res_re      = sd.pre_re;
         rsp_in.res_im      = sd.pre_im;
         rsp_in.div_by_zero = 1'b0;
         rsp_in.saturated   = sd.pre_sat;
      end else if (sd.dz) begin
         rsp_in.res_re      = '0;
         rsp_in.res_im      = '0;
         rsp_in.div_by_zero = 1'b1;
         rsp_in.saturated   = 1'b0;
      end else begin
         rsp_in.res_re      = qr.val;
         rsp_in.res_im      = qi.val;
         rsp_in.div_by_zero = 1'b0;
         rsp_in.saturated   = qr.sat | qi.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // zero divisor forces a clean zero result
   `CAU_ASSERT_IMPL(a_dz_zero, rsp_valid && rsp_data.div_by_zero,
      rsp_data.res_re == '0 && rsp_data.res_im == '0 && !rsp_data.saturated)

   // a clamp leaves at least one part at a range limit
   `CAU_ASSERT_IMPL(a_sat_limit, rsp_valid && rsp_data.saturated,
      rsp_data.res_re == SAT_MAX || rsp_data.res_re == SAT_MIN ||
      rsp_data.res_im == SAT_MAX || rsp_data.res_im == SAT_MIN)

   // a held result is still valid in the next cycle, with req_stall following rsp_stall
   `CAU_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall,
      rsp_valid && (req_stall == rsp_stall))

endmodule

FILE: bench/complex_arithmetic_unit_checker.sv
// Checker of the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 100ps

module complex_arithmetic_unit_checker import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   rsp_type expected_results[$];

   // clamp a wide signed value into 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                  inout logic sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return SAT_MAX;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return SAT_MIN;
      end
      return v[31:0];
   endfunction

   // n * 2^FRAC_BITS / d, truncated toward zero
   function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] n,
                                                           input logic signed [127:0] d);
      logic signed [127:0] m;
      m = (n < 0) ? -n : n;
      m = (m <<< FRAC_BITS) / d;
      return (n < 0) ? -m : m;
   endfunction

   function automatic rsp_type complex_result(input req_type r);
      rsp_type o;
      logic signed [127:0] xr, xi, yr, yi, a, b, d;
      logic sat;
      xr = 128'(r.x_re); xi = 128'(r.x_im); yr = 128'(r.y_re); yi = 128'(r.y_im);
      sat = 1'b0;
      o = '0;
      o.equal = (r.x_re == r.y_re) && (r.x_im == r.y_im);
      case (r.func)
         FUNC_ADD: begin
            a = xr + yr; b = xi + yi;
         end
         FUNC_SUB: begin
            a = xr - yr; b = xi - yi;
         end
         FUNC_MUL: begin
            a = (xr * yr - xi * yi) >>> FRAC_BITS;
            b = (xr * yi + xi * yr) >>> FRAC_BITS;
         end
         FUNC_DIV: begin
            d = yr * yr + yi * yi;
            if (d == 0) begin
               o.div_by_zero = 1'b1;
               a = 0; b = 0;
            end else begin
               a = scaled_quotient(xr * yr + xi * yi, d);
               b = scaled_quotient(xi * yr - xr * yi, d);
            end
         end
         default: begin
            a = 0; b = 0;
         end
      endcase
      o.res_re = clamp32(a, sat);
      o.res_im = clamp32(b, sat);
      o.saturated = sat;
      return o;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         errors <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(complex_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected re %h im %h eq %b dz %b sat %b",
                           $time, want.res_re, want.res_im, want.equal,
                           want.div_by_zero, want.saturated);
                  $display("%0t:          actual   re %h im %h eq %b dz %b sat %b",
                           $time, rsp_data.res_re, rsp_data.res_im, rsp_data.equal,
                           rsp_data.div_by_zero, rsp_data.saturated);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

FILE: bench/complex_arithmetic_unit_tb.sv
// Testbench top of the complex arithmetic unit: stimulus, idling and verdict.
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int LATENCY   = 37;
   localparam int WATCHDOG  = 2000;
   localparam int N_RANDOM  = 1400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      pending;

   // idle rates in percent; hold_rsp forces a long receiver hold-off
   int      send_idle = 0;
   int      recv_idle = 0;
   logic    hold_rsp = 1'b0;
   int      quiet_cycles = 0;

   always #6 clock = ~clock;

   complex_arithmetic_unit i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   complex_arithmetic_unit_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .errors, .pending
   );

   // receiver: random stall, or solid stall while held off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // operand values biased toward the edges of the range
   function automatic logic signed [31:0] pick_part();
      case ($urandom_range(7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 0;
         3: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
         4: return $signed($urandom) >>> $urandom_range(24);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.func = 3'($urandom_range(7));
      r.x_re = pick_part(); r.x_im = pick_part();
      r.y_re = pick_part(); r.y_im = pick_part();
      case ($urandom_range(9))
         0: begin r.y_re = r.x_re; r.y_im = r.x_im; end   // equal operands
         1: begin r.y_re = 0; r.y_im = 0; end             // zero divisor
         default: ;
      endcase
      return r;
   endfunction

   // one transfer on req; valid stays high back to back
   task automatic send(input req_type r);
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_pair(input logic [2:0] f, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic signed [31:0] c,
                            input logic signed [31:0] d);
      req_type r;
      r.func = f; r.x_re = a; r.x_im = b; r.y_re = c; r.y_im = d;
      send(r);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every code, range extremes, zero divisor, equality, saturation
      send_pair(FUNC_ADD, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
      send_pair(FUNC_ADD, SAT_MIN, 1, -1, -1);
      send_pair(FUNC_SUB, SAT_MIN, SAT_MAX, 1, -1);
      send_pair(FUNC_SUB, 5, 7, 5, 7);
      send_pair(FUNC_MUL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN);
      send_pair(FUNC_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_pair(FUNC_MUL, -1, 1, 1, -1);
      send_pair(FUNC_MUL, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
      send_pair(FUNC_DIV, 32'sh0001_0000, 0, 0, 0);
      send_pair(FUNC_DIV, SAT_MAX, SAT_MIN, 0, 0);
      send_pair(FUNC_DIV, SAT_MAX, SAT_MAX, 1, 0);
      send_pair(FUNC_DIV, SAT_MIN, SAT_MIN, -1, 0);
      send_pair(FUNC_DIV, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN);
      send_pair(FUNC_DIV, -7, 3, 32'sh0002_0000, 32'sh0001_0000);
      send_pair(FUNC_DIV, 1, -1, SAT_MAX, 1);
      send_pair(FUNC_CMP, 3, 4, 3, 4);
      send_pair(FUNC_CMP, SAT_MAX, SAT_MIN, 0, 0);
      send_pair(3'd5, 9, 9, 9, 9);
      send_pair(3'd6, -1, -1, 1, 1);
      send_pair(3'd7, SAT_MIN, 0, SAT_MIN, 1);

      // sender pauses until every result is back
      drain();

      // long receiver hold-off while items keep coming: pipeline fills, req stalls
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (150) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         repeat (60) send(random_item());
      join
      drain();

      // three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
         recv_idle = (phase == 0) ? 77 : (phase == 1) ? 23 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) send(random_item());
         if (phase == 1) drain();
      end

      drain();
      repeat (LATENCY + 5) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: complex_arithmetic_unit.f
+incdir+src
src/cau_pkg.sv
src/cau_front.sv
src/cau_div_lane.sv
src/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_checker.sv
bench/complex_arithmetic_unit_tb.sv
